// ----- sv/tfdt_pkg.sv -----
// Shared constants and helpers of the triangle fragment depth test.
// No dependencies.
package tfdt_pkg;

  // item opcodes
  localparam logic OP_TEST  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [15:0] FAR_RESET = 16'd64000;
  localparam logic [15:0] DEPTH_SAT = 16'hFFFF;

  // arithmetic widths
  localparam int DIFF_W = 17;  // coordinate difference, signed
  localparam int PROD_W = 34;  // 17x17 product, signed
  localparam int EDGE_W = 35;  // edge function, signed
  localparam int WGT_W  = 34;  // non-negative edge value / area, unsigned
  localparam int BQ_W   = 17;  // weight quotient, can reach 65536
  localparam int MZ_W   = 50;  // inv_z * weight
  localparam int NUM_W  = 52;  // sum of three products
  localparam int INV_W  = 16;
  localparam int RCP_NW = 23;  // dividend width of the depth reciprocal

  localparam logic [RCP_NW-1:0] RCP_ONE = 23'h400000;  // 2^22
  // reciprocal of anything up to this overflows 16 bits
  localparam logic [INV_W-1:0]  INV_SAT = 16'd64;

  function automatic logic [15:0] sat_weight(input logic [BQ_W-1:0] q);
    sat_weight = q[BQ_W-1] ? 16'hFFFF : q[15:0];
  endfunction

endpackage

// ----- sv/triangle_fragment_depth_test_unit.sv -----
// Triangle fragment depth test: edge functions, barycentric weights, depth, depth store.
// Throughput is one item per cycle while the output does not stall and no clearing pass runs.
// The pipeline moves as one; a stalled output holds every stage.
// Reset (rst_n, synchronous): far_depth returns to 64000 and a clearing pass writes
// 64000 to every store entry, with input held off meanwhile.
// Uses tfdt_pkg and tfdt_div.
module triangle_fragment_depth_test_unit #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [9:0]         in_pix_x,
  input  logic [8:0]         in_pix_y,
  input  logic signed [15:0] in_v0_x,
  input  logic signed [15:0] in_v0_y,
  input  logic [15:0]        in_v0_inv_z,
  input  logic signed [15:0] in_v1_x,
  input  logic signed [15:0] in_v1_y,
  input  logic [15:0]        in_v1_inv_z,
  input  logic signed [15:0] in_v2_x,
  input  logic signed [15:0] in_v2_y,
  input  logic [15:0]        in_v2_inv_z,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_covered,
  output logic               out_written,
  output logic [15:0]        out_frag_depth,
  output logic [15:0]        out_bary0,
  output logic [15:0]        out_bary1,
  output logic [15:0]        out_bary2
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // Stage order:
  //   differences, products, edge values, coverage / weights,
  //   inv_z products, sum, inverse depth divide,
  //   depth reciprocal, depth test against the store, then output.
  localparam int ST_D   = 3;
  localparam int ST_RCP = 22;
  localparam int ST_Q   = 37;
  localparam int ST_M   = 38;
  localparam int NST    = 39;
  localparam int BQ_DLY = ST_M - 20;  // weight quotients leave the divider at stage 20

  logic adv;

  // ---------------------------------------------------------------------------
  // Configuration and clearing pass
  // ---------------------------------------------------------------------------
  logic [15:0]   far_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_r <= tfdt_pkg::FAR_RESET;
    end else if (cfg_we) begin
      far_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // whole pipeline advances unless a finished item is stuck at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clr_busy_r;

  // ---------------------------------------------------------------------------
  // Sideband carried alongside the arithmetic
  // ---------------------------------------------------------------------------
  logic          vld_r [NST];
  logic          op_r  [NST];
  logic          ins_r [NST];
  logic          cov_r [NST];
  logic          sat_r [NST];
  logic [AW-1:0] adr_r [NST];

  logic          cov_c;
  logic          sat_c;
  logic          ins_c;
  logic [AW-1:0] adr_c;

  assign ins_c = (32'(in_pix_x) < FRAME_WIDTH) && (32'(in_pix_y) < FRAME_HEIGHT);
  assign adr_c = ins_c ? AW'(32'(in_pix_y) * 32'(FRAME_WIDTH) + 32'(in_pix_x)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid && !clr_busy_r;
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r[0]  <= in_op;
      ins_r[0] <= ins_c;
      adr_r[0] <= adr_c;
      cov_r[0] <= 1'b0;
      sat_r[0] <= 1'b0;
      for (int k = 1; k < NST; k++) begin
        op_r[k]  <= op_r[k-1];
        ins_r[k] <= ins_r[k-1];
        adr_r[k] <= adr_r[k-1];
        cov_r[k] <= (k == ST_D) ? cov_c : cov_r[k-1];
        sat_r[k] <= (k == ST_RCP) ? sat_c : sat_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: coordinate differences. Edge k = a*b - c*d with
  // k=0 area, k=1..3 the vertex weights w0..w2 at the pixel centre.
  // ---------------------------------------------------------------------------
  logic signed [tfdt_pkg::DIFF_W-1:0] x0, y0, x1, y1, x2, y2, sx, sy;
  logic signed [tfdt_pkg::DIFF_W-1:0] da_r [4];
  logic signed [tfdt_pkg::DIFF_W-1:0] db_r [4];
  logic signed [tfdt_pkg::DIFF_W-1:0] dc_r [4];
  logic signed [tfdt_pkg::DIFF_W-1:0] dd_r [4];
  logic [15:0] iz_r [ST_D+1][3];

  assign x0 = tfdt_pkg::DIFF_W'(in_v0_x);
  assign y0 = tfdt_pkg::DIFF_W'(in_v0_y);
  assign x1 = tfdt_pkg::DIFF_W'(in_v1_x);
  assign y1 = tfdt_pkg::DIFF_W'(in_v1_y);
  assign x2 = tfdt_pkg::DIFF_W'(in_v2_x);
  assign y2 = tfdt_pkg::DIFF_W'(in_v2_y);
  // pixel centre in 12.4: pix * 16 + 8
  assign sx = tfdt_pkg::DIFF_W'({in_pix_x, 4'h8});
  assign sy = tfdt_pkg::DIFF_W'({in_pix_y, 4'h8});

  always_ff @(posedge clk) begin
    if (adv) begin
      da_r[0] <= x2 - x0;  db_r[0] <= y1 - y0;  dc_r[0] <= y2 - y0;  dd_r[0] <= x1 - x0;
      da_r[1] <= sx - x1;  db_r[1] <= y2 - y1;  dc_r[1] <= sy - y1;  dd_r[1] <= x2 - x1;
      da_r[2] <= sx - x2;  db_r[2] <= y0 - y2;  dc_r[2] <= sy - y2;  dd_r[2] <= x0 - x2;
      da_r[3] <= sx - x0;  db_r[3] <= y1 - y0;  dc_r[3] <= sy - y0;  dd_r[3] <= x1 - x0;
      iz_r[0][0] <= in_v0_inv_z;
      iz_r[0][1] <= in_v1_inv_z;
      iz_r[0][2] <= in_v2_inv_z;
      for (int k = 1; k <= ST_D; k++) iz_r[k] <= iz_r[k-1];
    end
  end

  // Stages 1 and 2: products, then edge values
  logic signed [tfdt_pkg::PROD_W-1:0] p1_r [4];
  logic signed [tfdt_pkg::PROD_W-1:0] p2_r [4];
  logic signed [tfdt_pkg::EDGE_W-1:0] e_r  [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        p1_r[k] <= da_r[k] * db_r[k];
        p2_r[k] <= dc_r[k] * dd_r[k];
        e_r[k]  <= tfdt_pkg::EDGE_W'(p1_r[k]) - tfdt_pkg::EDGE_W'(p2_r[k]);
      end
    end
  end

  // Stage 3: coverage; zero area counts as outside
  logic [tfdt_pkg::WGT_W-1:0] w_r [3];
  logic [tfdt_pkg::WGT_W-1:0] area_r;

  assign cov_c = !e_r[0][tfdt_pkg::EDGE_W-1] && (e_r[0] != '0) &&
                 !e_r[1][tfdt_pkg::EDGE_W-1] && !e_r[2][tfdt_pkg::EDGE_W-1] &&
                 !e_r[3][tfdt_pkg::EDGE_W-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      area_r <= e_r[0][tfdt_pkg::WGT_W-1:0];
      for (int k = 0; k < 3; k++) w_r[k] <= e_r[k+1][tfdt_pkg::WGT_W-1:0];
    end
  end

  // Weights: w * 65536 / area, 17 stages, then delayed to meet the depth path.
  // Since w0+w1+w2 = area, each quotient of a covered pixel is at most 65536.
  logic [tfdt_pkg::BQ_W-1:0] bq_c [3];
  logic [tfdt_pkg::BQ_W-1:0] bq_r [BQ_DLY][3];

  for (genvar k = 0; k < 3; k++) begin : g_wdiv
    tfdt_div #(
      .NW(tfdt_pkg::WGT_W + 16),
      .DW(tfdt_pkg::WGT_W),
      .QW(tfdt_pkg::BQ_W)
    ) u_wdiv (
      .clk (clk),
      .en  (adv),
      .num ({w_r[k], 16'h0000}),
      .den (area_r),
      .quo (bq_c[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bq_r[0] <= bq_c;
      for (int k = 1; k < BQ_DLY; k++) bq_r[k] <= bq_r[k-1];
    end
  end

  // Stages 4 and 5: weighted sum of inv_z
  logic [tfdt_pkg::MZ_W-1:0]  mz_r [3];
  logic [tfdt_pkg::NUM_W-1:0] num_r;
  logic [tfdt_pkg::WGT_W-1:0] area_e_r;
  logic [tfdt_pkg::WGT_W-1:0] area_f_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) mz_r[k] <= iz_r[ST_D][k] * w_r[k];
      area_e_r <= area_r;
      num_r    <= tfdt_pkg::NUM_W'(mz_r[0]) + tfdt_pkg::NUM_W'(mz_r[1]) +
                  tfdt_pkg::NUM_W'(mz_r[2]);
      area_f_r <= area_e_r;
    end
  end

  // Interpolated 1/z = sum / area, below 2^16 by construction
  logic [tfdt_pkg::INV_W-1:0] inv_c;
  logic [15:0]                dq_c;

  tfdt_div #(
    .NW(tfdt_pkg::NUM_W),
    .DW(tfdt_pkg::WGT_W),
    .QW(tfdt_pkg::INV_W)
  ) u_invdiv (
    .clk (clk),
    .en  (adv),
    .num (num_r),
    .den (area_f_r),
    .quo (inv_c)
  );

  // Depth = 2^22 / inv; small inverse (including zero) saturates
  assign sat_c = inv_c <= tfdt_pkg::INV_SAT;

  tfdt_div #(
    .NW(tfdt_pkg::RCP_NW),
    .DW(tfdt_pkg::INV_W),
    .QW(16)
  ) u_rcpdiv (
    .clk (clk),
    .en  (adv),
    .num (tfdt_pkg::RCP_ONE),
    .den (inv_c),
    .quo (dq_c)
  );

  // ---------------------------------------------------------------------------
  // Depth store. Read as the item enters the test stage; written as it leaves.
  // The one write that lands between that read and the test is forwarded.
  // ---------------------------------------------------------------------------
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_r;
  logic [15:0]   dep_m_r;
  logic          lw_vld_r;
  logic [AW-1:0] lw_adr_r;
  logic [15:0]   lw_dat_r;
  logic [15:0]   stored;
  logic          pass_m;
  logic          clr_m;
  logic          pipe_we;
  logic [15:0]   pipe_wd;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r    <= mem[adr_r[ST_Q]];
      dep_m_r <= sat_r[ST_Q] ? tfdt_pkg::DEPTH_SAT : dq_c;
    end
  end

  assign stored  = (lw_vld_r && (lw_adr_r == adr_r[ST_M])) ? lw_dat_r : rd_r;
  assign pass_m  = vld_r[ST_M] && (op_r[ST_M] == tfdt_pkg::OP_TEST) && cov_r[ST_M] &&
                   ins_r[ST_M] && (dep_m_r < stored);
  assign clr_m   = vld_r[ST_M] && (op_r[ST_M] == tfdt_pkg::OP_CLEAR) && ins_r[ST_M];
  assign pipe_we = adv && (pass_m || clr_m);
  assign pipe_wd = clr_m ? far_r : dep_m_r;

  // clearing pass owns the write port while it runs; the pipeline is empty then
  assign mem_we = clr_busy_r || pipe_we;
  assign mem_wa = clr_busy_r ? clr_cnt_r : adr_r[ST_M];
  assign mem_wd = clr_busy_r ? tfdt_pkg::FAR_RESET : pipe_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r <= 1'b0;
    end else if (adv) begin
      lw_vld_r <= pipe_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lw_adr_r <= adr_r[ST_M];
      lw_dat_r <= pipe_wd;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic cov_out;

  assign cov_out = cov_r[ST_M] && (op_r[ST_M] == tfdt_pkg::OP_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[ST_M];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_covered    <= cov_out;
      out_written    <= pass_m;
      out_frag_depth <= (op_r[ST_M] == tfdt_pkg::OP_CLEAR) ? far_r :
                        (cov_out ? dep_m_r : 16'h0000);
      out_bary0      <= cov_out ? tfdt_pkg::sat_weight(bq_r[BQ_DLY-1][0]) : 16'h0000;
      out_bary1      <= cov_out ? tfdt_pkg::sat_weight(bq_r[BQ_DLY-1][1]) : 16'h0000;
      out_bary2      <= cov_out ? tfdt_pkg::sat_weight(bq_r[BQ_DLY-1][2]) : 16'h0000;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_written_covered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_written |-> out_covered)
    else $error("written item not covered");

  a_covered_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_covered |-> out_frag_depth >= 16'd64)
    else $error("covered depth below reciprocal floor");

  a_clear_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("input taken during clearing pass");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !vld_r[ST_M] && !lw_vld_r)
    else $error("pipeline write during clearing pass");

endmodule

// ----- sv/tfdt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Stand-alone; requires num < den * 2^QW.
module tfdt_div #(
  parameter int NW = 50,
  parameter int DW = 34,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int TW = QW + DW;

  logic [TW-1:0] numx;
  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [QW-1:0] q_nxt   [QW];
  logic [DW-1:0] den_nxt [QW];

  assign numx = TW'(num);

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = numx[TW-1:QW];
      assign low_in = numx[QW-1:0];
      assign q_in   = '0;
      assign den_nxt[i] = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign q_in   = q_r[i-1];
      assign den_nxt[i] = den_r[i-1];
    end

    assign trial      = {rem_in, low_in[QW-1]};
    assign ge         = trial >= {1'b0, den_nxt[i]};
    assign rem_nxt[i] = ge ? DW'(trial - {1'b0, den_nxt[i]}) : trial[DW-1:0];
    assign low_nxt[i] = low_in << 1;
    assign q_nxt[i]   = {q_in[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem_r[i] <= rem_nxt[i];
        low_r[i] <= low_nxt[i];
        q_r[i]   <= q_nxt[i];
        den_r[i] <= den_nxt[i];
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench of the triangle fragment depth test unit: directed and random items
// checked against an in-bench depth predictor. Depends on tfdt_pkg and the unit.
module tb;

  localparam int FW = 640;
  localparam int FH = 480;

  // one item and one result, as the ports carry them
  typedef struct packed {
    logic               op;
    logic [9:0]         px;
    logic [8:0]         py;
    logic signed [15:0] x0, y0;
    logic [15:0]        iz0;
    logic signed [15:0] x1, y1;
    logic [15:0]        iz1;
    logic signed [15:0] x2, y2;
    logic [15:0]        iz2;
  } frag_t;

  typedef struct packed {
    logic        covered;
    logic        written;
    logic [15:0] depth;
    logic [15:0] b0, b1, b2;
  } frag_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  frag_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  frag_res_t got;

  // predictor state
  logic [15:0] depth_mirror [FW*FH];
  logic [15:0] far_mirror;
  frag_res_t   pending_q[$];
  int          fails = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  always #4 clk = ~clk;

  triangle_fragment_depth_test_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_item.op), .in_pix_x(in_item.px), .in_pix_y(in_item.py),
    .in_v0_x(in_item.x0), .in_v0_y(in_item.y0), .in_v0_inv_z(in_item.iz0),
    .in_v1_x(in_item.x1), .in_v1_y(in_item.y1), .in_v1_inv_z(in_item.iz1),
    .in_v2_x(in_item.x2), .in_v2_y(in_item.y2), .in_v2_inv_z(in_item.iz2),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_covered(got.covered), .out_written(got.written),
    .out_frag_depth(got.depth),
    .out_bary0(got.b0), .out_bary1(got.b1), .out_bary2(got.b2)
  );

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
    return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
  endfunction

  function automatic logic [15:0] clamp_weight(longint w, longint area);
    longint q;
    q = (w * 65536) / area;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // works out the result of one item and updates the mirrored store
  function automatic frag_res_t depth_predict(frag_t it);
    frag_res_t r;
    bit        on_frame;
    int        idx;
    longint    sx, sy, area, w0, w1, w2, num, inv, dep;
    r = '0;
    on_frame = (it.px < FW) && (it.py < FH);
    idx = on_frame ? int'(it.py) * FW + int'(it.px) : 0;
    if (it.op == tfdt_pkg::OP_CLEAR) begin
      r.depth = far_mirror;
      if (on_frame) depth_mirror[idx] = far_mirror;
      return r;
    end
    sx = longint'(it.px) * 16 + 8;
    sy = longint'(it.py) * 16 + 8;
    area = edge_fn(it.x0, it.y0, it.x1, it.y1, it.x2, it.y2);
    w0 = edge_fn(it.x1, it.y1, it.x2, it.y2, sx, sy);
    w1 = edge_fn(it.x2, it.y2, it.x0, it.y0, sx, sy);
    w2 = edge_fn(it.x0, it.y0, it.x1, it.y1, sx, sy);
    if (w0 < 0 || w1 < 0 || w2 < 0 || area <= 0) return r;
    r.covered = 1'b1;
    r.b0 = clamp_weight(w0, area);
    r.b1 = clamp_weight(w1, area);
    r.b2 = clamp_weight(w2, area);
    num = longint'(it.iz0) * w0 + longint'(it.iz1) * w1 + longint'(it.iz2) * w2;
    inv = num / area;
    if (inv == 0) dep = 65535;
    else begin
      dep = (longint'(1) << 22) / inv;
      if (dep > 65535) dep = 65535;
    end
    r.depth = dep[15:0];
    if (on_frame && r.depth < depth_mirror[idx]) begin
      depth_mirror[idx] = r.depth;
      r.written = 1'b1;
    end
    return r;
  endfunction

  // sends one item, with random idle cycles ahead of it; valid stays up between
  // back-to-back items
  task automatic send_frag(frag_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(depth_predict(it));
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    frag_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result item with nothing expected");
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (got.covered !== e.covered) begin
          $error("covered exp %0d got %0d", e.covered, got.covered); fails++;
        end
        if (got.written !== e.written) begin
          $error("written exp %0d got %0d", e.written, got.written); fails++;
        end
        if (got.depth !== e.depth) begin
          $error("frag_depth exp %0d got %0d", e.depth, got.depth); fails++;
        end
        if (got.b0 !== e.b0) begin
          $error("bary0 exp %0d got %0d", e.b0, got.b0); fails++;
        end
        if (got.b1 !== e.b1) begin
          $error("bary1 exp %0d got %0d", e.b1, got.b1); fails++;
        end
        if (got.b2 !== e.b2) begin
          $error("bary2 exp %0d got %0d", e.b2, got.b2); fails++;
        end
      end
    end
  end

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // register write while the pipe is empty
  task automatic write_far(logic [15:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    far_mirror = v;
  endtask

  function automatic frag_t make_tri(logic op, int px, int py,
                                     int ax, int ay, int bx, int by,
                                     int cx, int cy);
    frag_t t;
    t.op = op; t.px = 10'(px); t.py = 9'(py);
    t.x0 = 16'(ax); t.y0 = 16'(ay); t.x1 = 16'(bx); t.y1 = 16'(by);
    t.x2 = 16'(cx); t.y2 = 16'(cy);
    t.iz0 = 16'($urandom); t.iz1 = 16'($urandom); t.iz2 = 16'($urandom);
    return t;
  endfunction

  // triangle around the pixel, wound so that the area comes out positive
  function automatic frag_t random_cover_tri();
    frag_t t;
    int cx, cy, r;
    bit in_frame;
    in_frame = ($urandom_range(9) != 0);
    cx = in_frame ? $urandom_range(FW - 1) : $urandom_range(1023);
    cy = in_frame ? $urandom_range(FH - 1) : $urandom_range(511);
    r  = ($urandom_range(3) == 0) ? $urandom_range(4000, 30) : $urandom_range(200, 8);
    t = make_tri(tfdt_pkg::OP_TEST, cx, cy,
                 cx*16 + 8 - $urandom_range(r), cy*16 + 8 + $urandom_range(r),
                 cx*16 + 8 + $urandom_range(r), cy*16 + 8 + $urandom_range(r),
                 cx*16 + 8 + $urandom_range(r) - r/2, cy*16 + 8 - $urandom_range(r));
    // x stays inside 16 bits even for pixels beyond the frame; those are legal items too
    if ($urandom_range(15) == 0) t.iz0 = 16'h0000;
    if ($urandom_range(15) == 0) begin
      t.iz0 = 16'hFFFF; t.iz1 = 16'hFFFF; t.iz2 = 16'hFFFF;
    end
    return t;
  endfunction

  task automatic test_directed();
    frag_t t;
    // covering triangle at the origin, wound to give positive area
    t = make_tri(tfdt_pkg::OP_TEST, 0, 0, 0, 0, 0, 64, 64, 0);
    send_frag(t);
    t = make_tri(tfdt_pkg::OP_TEST, 0, 0, 0, 0, 64, 0, 0, 64);    // negative winding
    send_frag(t);
    t = make_tri(tfdt_pkg::OP_TEST, 0, 0, 0, 0, 16, 16, 32, 32);  // zero area
    send_frag(t);
    // same pixel repeatedly: second pass closer, third farther than the second
    t = make_tri(tfdt_pkg::OP_TEST, 5, 5, 0, 0, 0, 320, 320, 0);
    t.iz0 = 16'd1000; t.iz1 = 16'd1000; t.iz2 = 16'd1000;
    send_frag(t);
    t.iz0 = 16'd4000; t.iz1 = 16'd4000; t.iz2 = 16'd4000;
    send_frag(t);
    t.iz0 = 16'd2000; t.iz1 = 16'd2000; t.iz2 = 16'd2000;
    send_frag(t);
    t.iz0 = 16'd0; t.iz1 = 16'd0; t.iz2 = 16'd0;          // zero reciprocal
    send_frag(t);
    t.iz0 = 16'hFFFF; t.iz1 = 16'hFFFF; t.iz2 = 16'hFFFF;
    send_frag(t);
    t.op = tfdt_pkg::OP_CLEAR;
    send_frag(t);
    // last pixel of the frame and pixels beyond it
    t = make_tri(tfdt_pkg::OP_TEST, FW-1, FH-1, -32768, -32768, -32768, 32767, 32767,
                 -32768);
    send_frag(t);
    t = make_tri(tfdt_pkg::OP_TEST, 1023, 511, -32768, -32768, -32768, 32767, 32767,
                 -32768);
    send_frag(t);
    t.op = tfdt_pkg::OP_CLEAR;
    send_frag(t);
    t = make_tri(tfdt_pkg::OP_TEST, 700, 10, 32767, 32767, 32767, -32768, -32768, 32767);
    send_frag(t);
    // vertex on the pixel centre: edge exactly zero
    t = make_tri(tfdt_pkg::OP_TEST, 2, 2, 40, 40, 40, 200, 200, 40);
    send_frag(t);
    t = make_tri(tfdt_pkg::OP_TEST, 9, 9, 0, 0, 0, 16, 16, 0);      // outside
    send_frag(t);
  endtask

  task automatic test_random(int n);
    frag_t t;
    repeat (n) begin
      case ($urandom_range(9))
        0: begin
          t = make_tri(tfdt_pkg::OP_CLEAR, $urandom_range(FW - 1), $urandom_range(FH - 1),
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          if ($urandom_range(3) == 0) t.px = 10'($urandom);
        end
        1: begin
          t = make_tri(tfdt_pkg::OP_TEST, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
        end
        default: t = random_cover_tri();
      endcase
      send_frag(t);
    end
  endtask

  task automatic test_far_settings();
    frag_t t;
    logic [15:0] vals [4] = '{16'd0, 16'hFFFF, 16'd1, 16'd12345};
    foreach (vals[i]) begin
      write_far(vals[i]);
      repeat (6) begin
        t = make_tri(tfdt_pkg::OP_CLEAR, $urandom_range(7), $urandom_range(7),
                     0, 0, 0, 0, 0, 0);
        send_frag(t);
        t = random_cover_tri();
        t.px = 10'($urandom_range(7)); t.py = 9'($urandom_range(7));
        t.x0 = 16'sd0; t.y0 = 16'sd0; t.x1 = 16'sd0; t.y1 = 16'sd256;
        t.x2 = 16'sd256; t.y2 = 16'sd0;
        send_frag(t);
      end
    end
    write_far(tfdt_pkg::FAR_RESET);
  endtask

  initial begin
    foreach (depth_mirror[i]) depth_mirror[i] = tfdt_pkg::FAR_RESET;
    far_mirror = tfdt_pkg::FAR_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_far_settings();
    // idling phases: none, sender only, receiver only, both
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(110);
    send_idle_pct = 50; recv_stall_pct = 0;  test_random(100);
    send_idle_pct = 0;  recv_stall_pct = 50; test_random(100);
    send_idle_pct = 15; recv_stall_pct = 15; test_random(100);
    drain_results();
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // the clearing pass after reset writes all 307200 store entries before input is taken
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tfdt_pkg.sv
sv/tfdt_div.sv
sv/triangle_fragment_depth_test_unit.sv
dv/tb.sv
